// ===== src/button_click_and_hold_detector_macros.svh =====
`ifndef BUTTON_CLICK_AND_HOLD_DETECTOR_MACROS_SVH
`define BUTTON_CLICK_AND_HOLD_DETECTOR_MACROS_SVH

// Both macros expect clk and rst in the scope where they are used.
`define BCHD_ASSERT_IMPL(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

`define BCHD_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== src/bchd_pkg.sv =====
`default_nettype none

package bchd_pkg;

  localparam int unsigned HOLD_THIRD_MS       = 5000;
  localparam int unsigned HOLD_FOURTH_MS      = 10000;
  localparam int unsigned HOLD_FIFTH_MS       = 15000;
  localparam int unsigned DEBOUNCE_SAMPLES    = 4;
  localparam int unsigned DEBOUNCE_SPACING_MS = 2;

  localparam int unsigned DB_PHASE_W = $clog2(DEBOUNCE_SAMPLES + 2);

  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned QFILL_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] REG_NORMAL_SCAN  = 3'd0;
  localparam logic [2:0] REG_FAST_SCAN    = 3'd1;
  localparam logic [2:0] REG_PRESS_WINDOW = 3'd2;
  localparam logic [2:0] REG_SETTLE_EXTRA = 3'd3;
  localparam logic [2:0] REG_ERROR_HOLD   = 3'd4;
  localparam logic [2:0] REG_MIN_POLLS    = 3'd5;
  localparam logic [2:0] REG_HOLD_FIRST   = 3'd6;
  localparam logic [2:0] REG_HOLD_SECOND  = 3'd7;

  localparam logic [4:0] EV_START   = 5'd0;
  localparam logic [4:0] EV_HOLD1   = 5'd1;
  localparam logic [4:0] EV_HOLD2   = 5'd2;
  localparam logic [4:0] EV_HOLD3   = 5'd3;
  localparam logic [4:0] EV_HOLD4   = 5'd4;
  localparam logic [4:0] EV_HOLD5   = 5'd5;
  localparam logic [4:0] EV_RELEASE = 5'd6;
  localparam logic [4:0] EV_NOPRESS = 5'd7;
  localparam logic [4:0] EV_NONE    = 5'd0;

  typedef struct packed {
    logic [9:0]  normal_scan_ms;
    logic [9:0]  fast_scan_ms;
    logic [15:0] press_window_ms;
    logic [15:0] settle_extra_ms;
    logic [31:0] error_hold_ms;
    logic [7:0]  min_hold_polls;
    logic [15:0] hold_first_ms;
    logic [15:0] hold_second_ms;
  } cfg_t;

  typedef struct packed {
    logic [4:0] event_res;
    logic       last;
  } res_item_t;

  typedef struct packed {
    logic [1:0] count;
    res_item_t  first;
    res_item_t  second;
  } res_pair_t;

  function automatic logic [4:0] count_code(input logic [7:0] presses);
    logic [4:0] code;
    case (presses)
      8'd1:    code = 5'd8;
      8'd2:    code = 5'd9;
      8'd3:    code = 5'd10;
      8'd4:    code = 5'd11;
      8'd5:    code = 5'd12;
      8'd6:    code = 5'd13;
      8'd8:    code = 5'd14;
      8'd10:   code = 5'd15;
      8'd12:   code = 5'd16;
      default: code = 5'd0;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== src/bchd_tick_if.sv =====
`default_nettype none

interface bchd_tick_if;
  logic valid;
  logic ready;
  logic pressed;

  modport source (output valid, output pressed, input ready);
  modport sink (input valid, input pressed, output ready);
endinterface

`default_nettype wire

// ===== src/bchd_result_if.sv =====
`default_nettype none

interface bchd_result_if;
  logic       valid;
  logic       ready;
  logic [4:0] event_res;
  logic       last;

  modport source (output valid, output event_res, output last, input ready);
  modport sink (input valid, input event_res, input last, output ready);
endinterface

`default_nettype wire

// ===== src/button_click_and_hold_detector.sv =====
// A tick request is registered on acceptance and processed once the result queue has room,
// and its results are written into the result queue, which offers them from there.
// Throughput: one tick request per cycle; results leave at one per cycle, while the
// receiver is ready, through a four-entry result queue, and a tick waits in the input
// register while the queue holds more than two results.
// Reset (synchronous, active high) restores register defaults, core state and queue pointers.
`default_nettype none
`include "button_click_and_hold_detector_macros.svh"

module button_click_and_hold_detector
  import bchd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  bchd_tick_if.sink              tick,
  bchd_result_if.source          result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  cfg_t                 cfg;
  res_pair_t            res;
  logic [QFILL_W-1:0]   fill;
  logic                 stage_valid;
  logic                 stage_pressed;
  logic                 advance;

  assign advance    = stage_valid && (fill <= QFILL_W'(QUEUE_DEPTH - 2));
  assign tick.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (tick.valid && tick.ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      stage_pressed <= tick.pressed;
    end
  end

  bchd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bchd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (advance),
    .pressed (stage_pressed),
    .res     (res)
  );

  bchd_out_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (advance),
    .res    (res),
    .fill   (fill),
    .result (result)
  );

  `BCHD_ASSERT_IMPL(a_fill_bound, 1'b1, fill <= QFILL_W'(QUEUE_DEPTH), "result queue overfilled")
  `BCHD_ASSERT_IMPL(a_valid_fill, 1'b1, result.valid == (fill != '0), "result valid disagrees with fill")
  `BCHD_ASSERT_NEXT(a_pair_lands, advance && res.count == 2'd2, fill != '0, "result pair lost")
  `BCHD_ASSERT_IMPL(a_pair_last, advance && res.count == 2'd2, !res.first.last && res.second.last, "last flag misplaced in result pair")

endmodule

`default_nettype wire

// ===== src/bchd_cfg_regs.sv =====
`default_nettype none

module bchd_cfg_regs
  import bchd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.normal_scan_ms  <= 10'd20;
      cfg.fast_scan_ms    <= 10'd10;
      cfg.press_window_ms <= 16'd700;
      cfg.settle_extra_ms <= 16'd200;
      cfg.error_hold_ms   <= 32'd30000;
      cfg.min_hold_polls  <= 8'd3;
      cfg.hold_first_ms   <= 16'd500;
      cfg.hold_second_ms  <= 16'd800;
    end else if (wr_en) begin
      case (idx)
        REG_NORMAL_SCAN:  cfg.normal_scan_ms  <= pwdata[9:0];
        REG_FAST_SCAN:    cfg.fast_scan_ms    <= pwdata[9:0];
        REG_PRESS_WINDOW: cfg.press_window_ms <= pwdata[15:0];
        REG_SETTLE_EXTRA: cfg.settle_extra_ms <= pwdata[15:0];
        REG_ERROR_HOLD:   cfg.error_hold_ms   <= pwdata;
        REG_MIN_POLLS:    cfg.min_hold_polls  <= pwdata[7:0];
        REG_HOLD_FIRST:   cfg.hold_first_ms   <= pwdata[15:0];
        REG_HOLD_SECOND:  cfg.hold_second_ms  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_NORMAL_SCAN:  prdata = {22'd0, cfg.normal_scan_ms};
      REG_FAST_SCAN:    prdata = {22'd0, cfg.fast_scan_ms};
      REG_PRESS_WINDOW: prdata = {16'd0, cfg.press_window_ms};
      REG_SETTLE_EXTRA: prdata = {16'd0, cfg.settle_extra_ms};
      REG_ERROR_HOLD:   prdata = cfg.error_hold_ms;
      REG_MIN_POLLS:    prdata = {24'd0, cfg.min_hold_polls};
      REG_HOLD_FIRST:   prdata = {16'd0, cfg.hold_first_ms};
      REG_HOLD_SECOND:  prdata = {16'd0, cfg.hold_second_ms};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/bchd_core.sv =====
`default_nettype none

module bchd_core
  import bchd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  step,
  input  wire logic  pressed,
  output res_pair_t  res
);

  typedef enum logic [3:0] {
    HP_WAIT   = 4'd0,
    HP_ARMED  = 4'd1,
    HP_HOLD1  = 4'd2,
    HP_HOLD2  = 4'd3,
    HP_HOLD3  = 4'd4,
    HP_HOLD4  = 4'd5,
    HP_HOLD5  = 4'd6,
    HP_ERROR  = 4'd14,
    HP_IDLE   = 4'd15
  } hold_phase_t;

  logic [31:0]           now_ms, now_ms_next;
  logic [31:0]           scan_mark, scan_mark_next;
  logic [31:0]           press_mark, press_mark_next;
  logic [31:0]           hold_mark, hold_mark_next;
  logic                  prev_level, prev_level_next;
  hold_phase_t           hold_phase, hold_phase_next;
  logic [7:0]            poll_count, poll_count_next;
  logic [7:0]            press_count, press_count_next;
  logic                  count_pending, count_pending_next;
  logic [DB_PHASE_W-1:0] debounce_phase, debounce_phase_next;
  logic                  debounce_good, debounce_good_next;

  logic [31:0]           scan_gap;
  logic [31:0]           press_gap;
  logic [31:0]           held;
  logic [31:0]           sample_at;
  logic [31:0]           interval;
  logic [31:0]           report_limit;
  logic [DB_PHASE_W-1:0] phase_inc;
  logic                  good;
  logic [7:0]            polls;
  logic [4:0]            code;
  logic [4:0]            end_event;
  hold_phase_t           ph;

  always_comb begin
    now_ms_next         = now_ms + 32'd1;
    scan_mark_next      = scan_mark;
    press_mark_next     = press_mark;
    hold_mark_next      = hold_mark;
    prev_level_next     = prev_level;
    hold_phase_next     = hold_phase;
    poll_count_next     = poll_count;
    press_count_next    = press_count;
    count_pending_next  = count_pending;
    debounce_phase_next = debounce_phase;
    debounce_good_next  = debounce_good;
    res                 = '0;

    scan_gap     = now_ms - scan_mark;
    press_gap    = now_ms - press_mark;
    sample_at    = 32'(debounce_phase) * 32'(DEBOUNCE_SPACING_MS);
    interval     = prev_level ? {22'd0, cfg.fast_scan_ms} : {22'd0, cfg.normal_scan_ms};
    report_limit = 32'({1'b0, cfg.press_window_ms} + {1'b0, cfg.settle_extra_ms});
    phase_inc    = debounce_phase + 1'b1;
    good         = debounce_good && pressed;
    polls        = (poll_count == 8'hFF) ? poll_count : poll_count + 8'd1;
    code         = count_code(press_count);
    end_event    = (hold_phase != HP_IDLE) ? EV_RELEASE : EV_NOPRESS;
    ph           = (hold_phase == HP_IDLE) ? HP_WAIT : hold_phase;
    held         = (hold_phase == HP_IDLE) ? 32'd0 : now_ms - hold_mark;

    if (debounce_phase != '0) begin
      if (scan_gap == sample_at) begin
        if (32'(phase_inc) > 32'(DEBOUNCE_SAMPLES)) begin
          if (good) begin
            res.count           = 2'd1;
            res.first.event_res = EV_START;
            res.first.last      = 1'b1;
            if (press_gap < {16'd0, cfg.press_window_ms}) begin
              press_count_next = (press_count == 8'hFF) ? press_count : press_count + 8'd1;
            end else begin
              press_count_next = 8'd1;
            end
            press_mark_next    = now_ms;
            count_pending_next = 1'b1;
            poll_count_next    = 8'd0;
          end
          prev_level_next     = 1'b1;
          scan_mark_next      = now_ms;
          debounce_phase_next = '0;
          debounce_good_next  = 1'b0;
        end else begin
          debounce_phase_next = phase_inc;
          debounce_good_next  = good;
        end
      end
    end else if (scan_gap >= interval) begin
      scan_mark_next = now_ms;
      if (!prev_level && pressed) begin
        debounce_phase_next = DB_PHASE_W'(1);
        debounce_good_next  = 1'b1;
      end else begin
        prev_level_next = pressed;
        if (prev_level && pressed) begin
          poll_count_next = polls;
          if (hold_phase == HP_IDLE) begin
            hold_mark_next = now_ms;
          end
          if (held > cfg.error_hold_ms) begin
            ph = HP_ERROR;
          end
          res.first.last = 1'b1;
          case (ph)
            HP_WAIT: begin
              if (polls >= cfg.min_hold_polls) ph = HP_ARMED;
            end
            HP_ARMED: begin
              if (held > {16'd0, cfg.hold_first_ms}) begin
                ph = HP_HOLD1;
                res.count = 2'd1;
                res.first.event_res = EV_HOLD1;
              end
            end
            HP_HOLD1: begin
              if (held > {16'd0, cfg.hold_second_ms}) begin
                ph = HP_HOLD2;
                res.count = 2'd1;
                res.first.event_res = EV_HOLD2;
              end
            end
            HP_HOLD2: begin
              if (held > 32'(HOLD_THIRD_MS)) begin
                ph = HP_HOLD3;
                res.count = 2'd1;
                res.first.event_res = EV_HOLD3;
              end
            end
            HP_HOLD3: begin
              if (held > 32'(HOLD_FOURTH_MS)) begin
                ph = HP_HOLD4;
                res.count = 2'd1;
                res.first.event_res = EV_HOLD4;
              end
            end
            HP_HOLD4: begin
              if (held > 32'(HOLD_FIFTH_MS)) begin
                ph = HP_HOLD5;
                res.count = 2'd1;
                res.first.event_res = EV_HOLD5;
              end
            end
            default: ;
          endcase
          hold_phase_next = ph;
        end else if (!prev_level && !pressed) begin
          res.count           = 2'd1;
          res.first.event_res = end_event;
          res.first.last      = 1'b1;
          if (count_pending && press_gap > {16'd0, cfg.press_window_ms}) begin
            count_pending_next = 1'b0;
            if (press_gap <= report_limit && code != EV_NONE) begin
              res.count            = 2'd2;
              res.first.event_res  = code;
              res.first.last       = 1'b0;
              res.second.event_res = end_event;
              res.second.last      = 1'b1;
            end
          end
          hold_phase_next = HP_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms         <= '0;
      scan_mark      <= '0;
      press_mark     <= '0;
      hold_mark      <= '0;
      prev_level     <= 1'b0;
      hold_phase     <= HP_IDLE;
      poll_count     <= '0;
      press_count    <= '0;
      count_pending  <= 1'b0;
      debounce_phase <= '0;
      debounce_good  <= 1'b0;
    end else if (step) begin
      now_ms         <= now_ms_next;
      scan_mark      <= scan_mark_next;
      press_mark     <= press_mark_next;
      hold_mark      <= hold_mark_next;
      prev_level     <= prev_level_next;
      hold_phase     <= hold_phase_next;
      poll_count     <= poll_count_next;
      press_count    <= press_count_next;
      count_pending  <= count_pending_next;
      debounce_phase <= debounce_phase_next;
      debounce_good  <= debounce_good_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/bchd_out_queue.sv =====
`default_nettype none

module bchd_out_queue
  import bchd_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire res_pair_t      res,
  output logic [QFILL_W-1:0]  fill,
  bchd_result_if.source       result
);

  res_item_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W-1:0]   wr_ptr_second;
  logic [1:0]          push_n;
  logic                pop;

  assign push_n        = push ? res.count : 2'd0;
  assign pop           = result.valid && result.ready;
  assign wr_ptr_second = wr_ptr + 1'b1;

  assign result.valid     = (fill != '0);
  assign result.event_res = entries[rd_ptr].event_res;
  assign result.last      = entries[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries[wr_ptr] <= res.first;
    end
    if (push_n == 2'd2) begin
      entries[wr_ptr_second] <= res.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + QFILL_W'(push_n) - QFILL_W'(pop);
    end
  end

endmodule

`default_nettype wire
